/* sv/scab_pkg.sv */
// Shared types, codes and sizing for the size-class bitmap allocator.
// Used by the bitmap RAM, the address unit and the top level; no dependencies.
`default_nettype none

package scab_pkg;

    localparam int SMALL_BLOCKS = 1024;
    localparam int MID_BLOCKS   = 256;
    localparam int LARGE_BLOCKS = 512;

    localparam int SMALL_WORDS = (SMALL_BLOCKS + 63) / 64;
    localparam int MID_WORDS   = (MID_BLOCKS + 63) / 64;
    localparam int LARGE_WORDS = (LARGE_BLOCKS + 63) / 64;
    localparam int TOTAL_WORDS = SMALL_WORDS + MID_WORDS + LARGE_WORDS;
    localparam int WADDR_W     = $clog2(TOTAL_WORDS);

    localparam int MAX_WORDS = (SMALL_WORDS > MID_WORDS) ?
        ((SMALL_WORDS > LARGE_WORDS) ? SMALL_WORDS : LARGE_WORDS) :
        ((MID_WORDS > LARGE_WORDS) ? MID_WORDS : LARGE_WORDS);
    localparam int WIDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int IDX_W  = WIDX_W + 6;

    // valid bits in the last word of each pool
    localparam int SMALL_REM = SMALL_BLOCKS - 64 * (SMALL_WORDS - 1);
    localparam int MID_REM   = MID_BLOCKS - 64 * (MID_WORDS - 1);
    localparam int LARGE_REM = LARGE_BLOCKS - 64 * (LARGE_WORDS - 1);

    // large pool: span in bytes and divide-by-3 reciprocal on (offset >> 5)
    localparam int LARGE_SPAN = 96 * LARGE_BLOCKS;
    localparam int XW         = $clog2(3 * LARGE_BLOCKS);
    localparam int DIV_S      = XW + 2;
    localparam int DIV_M      = ((2 ** DIV_S) + 2) / 3;
    localparam int MW         = XW + 1;
    localparam int PW         = XW + MW;

    typedef logic [1:0] t_code;

    localparam t_code OP_ALLOC = 2'd0;
    localparam t_code OP_FREE  = 2'd1;
    localparam t_code OP_QUERY = 2'd2;

    localparam t_code ST_OK     = 2'd0;
    localparam t_code ST_FULL   = 2'd1;
    localparam t_code ST_HEAP   = 2'd2;
    localparam t_code ST_DOUBLE = 2'd3;

    localparam t_code POOL_SMALL = 2'd0;
    localparam t_code POOL_MID   = 2'd1;
    localparam t_code POOL_LARGE = 2'd2;
    localparam t_code POOL_NONE  = 2'd3;

    localparam t_code CFG_SMALL_BASE = 2'd0;
    localparam t_code CFG_MID_BASE   = 2'd1;
    localparam t_code CFG_LARGE_BASE = 2'd2;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic        sub;
        t_code       pool;
    } t_alu_req;

    typedef struct packed {
        logic [31:0]      sum;
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic [XW-1:0]    x;
    } t_alu_rsp;

    function automatic logic [WADDR_W-1:0] pool_wbase(t_code p);
        logic [WADDR_W-1:0] r;
        case (p)
            POOL_SMALL: r = '0;
            POOL_MID:   r = WADDR_W'(SMALL_WORDS);
            default:    r = WADDR_W'(SMALL_WORDS + MID_WORDS);
        endcase
        return r;
    endfunction

    function automatic logic [WIDX_W-1:0] pool_last_word(t_code p);
        logic [WIDX_W-1:0] r;
        case (p)
            POOL_SMALL: r = WIDX_W'(SMALL_WORDS - 1);
            POOL_MID:   r = WIDX_W'(MID_WORDS - 1);
            default:    r = WIDX_W'(LARGE_WORDS - 1);
        endcase
        return r;
    endfunction

    function automatic logic [63:0] pool_last_mask(t_code p);
        logic [6:0]  rem;
        logic [63:0] m;
        case (p)
            POOL_SMALL: rem = 7'(SMALL_REM);
            POOL_MID:   rem = 7'(MID_REM);
            default:    rem = 7'(LARGE_REM);
        endcase
        if (rem == 7'd64) begin
            m = '1;
        end else begin
            m = (64'd1 << rem) - 64'd1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* sv/size_class_bitmap_allocator_top.sv */
// Size-class bitmap allocator: one word in, one word out, one item at a time.
// Allocate: scans the pool's bitmap from word 0, one bitmap word per cycle, up to the
//   first free bit. An out-of-class size or an unused code goes straight to the result.
// Release/query: the shared address unit tests one pool a cycle, small, mid then large.
// Reset: synchronous; a clearing pass zeroes all TOTAL_WORDS (28 by default) words of
//   the bitmap RAM, with input stalled; pool bases reset to zero.
`default_nettype none

module size_class_bitmap_allocator_top import scab_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_request_size,
    input  wire logic [31:0] i_block_address,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [31:0] o_result_address,
    output logic      [1:0]  o_status,
    output logic      [1:0]  o_pool_hit,
    output logic             o_is_allocated,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_AREAD, S_ACHK, S_AADD, S_FIND,
        S_DIV, S_DIVCHK, S_BREAD, S_BCHK, S_DONE
    } t_state;

    t_state             r_state;
    logic [WADDR_W-1:0] r_clr;
    t_code              r_op;
    logic [31:0]        r_addr;
    logic [31:0]        r_small_base;
    logic [31:0]        r_mid_base;
    logic [31:0]        r_large_base;
    t_code              r_pool;
    logic [WIDX_W-1:0]  r_word;
    logic [IDX_W-1:0]   r_idx;
    logic [XW-1:0]      r_x;
    logic [PW-1:0]      r_prod;
    logic [31:0]        r_p_addr;
    t_code              r_p_status;
    t_code              r_p_hit;
    logic               r_p_alloc;
    logic               r_out_valid;
    logic [31:0]        r_o_addr;
    t_code              r_o_status;
    t_code              r_o_hit;
    logic               r_o_alloc;

    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;
    logic [31:0]        base_sel;
    logic [31:0]        offset;
    logic [IDX_W+1:0]   idx3;
    logic               ram_we;
    logic [WADDR_W-1:0] ram_waddr;
    logic [63:0]        ram_wdata;
    logic [WADDR_W-1:0] ram_raddr;
    logic [63:0]        ram_rdata;
    logic [WIDX_W-1:0]  rd_word;
    logic [63:0]        freebits;
    logic [5:0]         ffs;
    logic               found;
    logic               last_word;
    logic [WADDR_W-1:0] cur_waddr;
    logic [63:0]        bit_mask;
    logic [5:0]         bit_sel;
    logic [XW-1:0]      q;
    logic [XW+1:0]      q3;
    t_code              size_pool;

    scab_bitmap_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    scab_addr_unit u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    always_comb begin
        case (r_pool)
            POOL_SMALL: base_sel = r_small_base;
            POOL_MID:   base_sel = r_mid_base;
            default:    base_sel = r_large_base;
        endcase

        idx3 = (IDX_W + 2)'({r_idx, 1'b0}) + (IDX_W + 2)'(r_idx);
        case (r_pool)
            POOL_SMALL: offset = 32'(r_idx) << 4;
            POOL_MID:   offset = 32'(r_idx) << 5;
            default:    offset = 32'(idx3) << 5;
        endcase

        alu_req.pool = r_pool;
        if (r_state == S_AADD) begin
            alu_req.a   = base_sel;
            alu_req.b   = offset;
            alu_req.sub = 1'b0;
        end else begin
            alu_req.a   = r_addr;
            alu_req.b   = base_sel;
            alu_req.sub = 1'b1;
        end
    end

    // first free bit of the word under scan; bits past the pool end count as used
    always_comb begin
        last_word = (r_word == pool_last_word(r_pool));
        freebits  = ~ram_rdata & (last_word ? pool_last_mask(r_pool) : '1);
        found     = |freebits;
        ffs       = '0;
        for (int b = 63; b >= 0; b--) begin
            if (freebits[b]) begin
                ffs = 6'(b);
            end
        end
    end

    always_comb begin
        case (r_state)
            S_AREAD: rd_word = '0;
            S_ACHK:  rd_word = r_word + 1'b1;
            S_BREAD: rd_word = r_idx[IDX_W-1:6];
            default: rd_word = r_word;
        endcase
        ram_raddr = pool_wbase(r_pool) + WADDR_W'(rd_word);

        bit_sel  = (r_state == S_ACHK) ? ffs : r_idx[5:0];
        bit_mask = 64'd1 << bit_sel;
        cur_waddr = pool_wbase(r_pool) +
            WADDR_W'((r_state == S_ACHK) ? r_word : r_idx[IDX_W-1:6]);

        ram_we    = 1'b0;
        ram_waddr = cur_waddr;
        ram_wdata = ram_rdata | bit_mask;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            S_ACHK: begin
                ram_we = found;
            end
            S_BCHK: begin
                ram_we    = (r_op == OP_FREE);
                ram_wdata = ram_rdata & ~bit_mask;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        q  = XW'(r_prod >> DIV_S);
        q3 = (XW + 2)'({q, 1'b0}) + (XW + 2)'(q);

        if (i_request_size >= 32'd1 && i_request_size <= 32'd16) begin
            size_pool = POOL_SMALL;
        end else if (i_request_size >= 32'd17 && i_request_size <= 32'd32) begin
            size_pool = POOL_MID;
        end else if (i_request_size >= 32'd33 && i_request_size <= 32'd96) begin
            size_pool = POOL_LARGE;
        end else begin
            size_pool = POOL_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
            r_small_base <= '0;
            r_mid_base   <= '0;
            r_large_base <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SMALL_BASE: r_small_base <= i_cfg_data;
                    CFG_MID_BASE:   r_mid_base   <= i_cfg_data;
                    CFG_LARGE_BASE: r_large_base <= i_cfg_data;
                    default: ;
                endcase
            end

            // S_DONE reloads the output register itself
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == WADDR_W'(TOTAL_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op       <= i_operation;
                        r_addr     <= i_block_address;
                        r_p_addr   <= '0;
                        r_p_status <= ST_HEAP;
                        r_p_hit    <= POOL_NONE;
                        r_p_alloc  <= 1'b0;
                        r_word     <= '0;
                        case (i_operation)
                            OP_ALLOC: begin
                                r_pool <= size_pool;
                                if (size_pool == POOL_NONE) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_AREAD;
                                end
                            end
                            OP_FREE, OP_QUERY: begin
                                r_pool  <= POOL_SMALL;
                                r_state <= S_FIND;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_AREAD: begin
                    r_state <= S_ACHK;
                end
                S_ACHK: begin
                    if (found) begin
                        r_idx   <= {r_word, ffs};
                        r_state <= S_AADD;
                    end else if (last_word) begin
                        r_p_status <= ST_FULL;
                        r_p_hit    <= r_pool;
                        r_state    <= S_DONE;
                    end else begin
                        // next word's read is already issued
                        r_word <= r_word + 1'b1;
                    end
                end
                S_AADD: begin
                    r_p_addr   <= alu_rsp.sum;
                    r_p_status <= ST_OK;
                    r_p_hit    <= r_pool;
                    r_state    <= S_DONE;
                end
                S_FIND: begin
                    if (r_pool == POOL_LARGE) begin
                        r_x     <= alu_rsp.x;
                        r_state <= alu_rsp.hit ? S_DIV : S_DONE;
                    end else if (alu_rsp.hit) begin
                        r_idx   <= alu_rsp.idx;
                        r_state <= S_BREAD;
                    end else begin
                        r_pool <= r_pool + 1'b1;
                    end
                end
                S_DIV: begin
                    r_prod  <= PW'(r_x) * PW'(DIV_M);
                    r_state <= S_DIVCHK;
                end
                S_DIVCHK: begin
                    if (q3 == (XW + 2)'(r_x)) begin
                        r_idx   <= IDX_W'(q);
                        r_state <= S_BREAD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_BREAD: begin
                    r_state <= S_BCHK;
                end
                S_BCHK: begin
                    r_p_hit <= r_pool;
                    if (r_op == OP_FREE) begin
                        r_p_status <= ram_rdata[r_idx[5:0]] ? ST_OK : ST_DOUBLE;
                    end else begin
                        r_p_status <= ST_OK;
                        r_p_alloc  <= ram_rdata[r_idx[5:0]];
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_o_addr    <= r_p_addr;
                        r_o_status  <= r_p_status;
                        r_o_hit     <= r_p_hit;
                        r_o_alloc   <= r_p_alloc;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_result_address = r_o_addr;
    assign o_status         = r_o_status;
    assign o_pool_hit       = r_o_hit;
    assign o_is_allocated   = r_o_alloc;
    assign o_cfg_ready      = i_rst_n;

endmodule

`default_nettype wire

/* sv/scab_bitmap_ram.sv */
// Bitmap store for all three pools, one 64-bit word per entry.
// One write port and one registered read port; sized from scab_pkg.
`default_nettype none

module scab_bitmap_ram import scab_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [WADDR_W-1:0] i_waddr,
    input  wire logic [63:0]        i_wdata,
    input  wire logic [WADDR_W-1:0] i_raddr,
    output logic      [63:0]        o_rdata
);

    logic [63:0] r_mem [TOTAL_WORDS];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/scab_addr_unit.sv */
// Shared 32-bit add/subtract unit with pool membership decode on its result.
// Depends on scab_pkg for the request and response structs and pool sizes.
`default_nettype none

module scab_addr_unit import scab_pkg::*; (
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);

    logic [31:0] d;

    always_comb begin
        d = i_req.sub ? (i_req.a - i_req.b) : (i_req.a + i_req.b);
        o_rsp.sum = d;
        o_rsp.x   = XW'(d >> 5);
        o_rsp.idx = '0;
        o_rsp.hit = 1'b0;
        case (i_req.pool)
            POOL_SMALL: begin
                o_rsp.hit = (d[3:0] == 4'd0) && ((d >> 4) < 32'(SMALL_BLOCKS));
                o_rsp.idx = IDX_W'(d >> 4);
            end
            POOL_MID: begin
                o_rsp.hit = (d[4:0] == 5'd0) && ((d >> 5) < 32'(MID_BLOCKS));
                o_rsp.idx = IDX_W'(d >> 5);
            end
            POOL_LARGE: begin
                // in range and 32-aligned; the multiple-of-3 test follows
                o_rsp.hit = (d[4:0] == 5'd0) && (d < 32'(LARGE_SPAN));
            end
            default: begin
                o_rsp.hit = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for size_class_bitmap_allocator_top: a directed table, then paced
// random traffic; each result checked against its table row or an in-bench bitmap model.
// Depends on scab_pkg and the allocator RTL.

module testbench;
    import scab_pkg::*;

    localparam t_code OP_RESERVED = 2'd3;
    localparam t_code CFG_UNUSED  = 2'd3;

    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
    localparam logic [31:0] SMALL_BYTES = 32'd16;
    localparam logic [31:0] MID_BYTES   = 32'd32;
    localparam logic [31:0] LARGE_BYTES = 32'd96;

    localparam int MAX_BLOCKS = (SMALL_BLOCKS > MID_BLOCKS) ?
        ((SMALL_BLOCKS > LARGE_BLOCKS) ? SMALL_BLOCKS : LARGE_BLOCKS) :
        ((MID_BLOCKS > LARGE_BLOCKS) ? MID_BLOCKS : LARGE_BLOCKS);

    localparam int    DRAIN_CYCLES = 32;
    localparam int    HOLD_CYCLES  = 400;
    localparam int    FILL_CAP     = 1500;
    localparam int    REPORT_LIMIT = 40;
    localparam longint RUN_LIMIT_NS = 5_000_000;

    typedef struct packed {
        logic [31:0] addr;
        t_code       status;
        t_code       pool;
        logic        used;
    } t_result;

    typedef struct packed {
        t_code       op;
        logic [31:0] size;
        logic [31:0] addr;
        logic        typed;
        t_result     want;
    } t_vector;

    // Bases are all zero after reset, so the three pools overlap at address 0.
    localparam int DIRECTED_ROWS = 25;
    localparam t_vector DIRECTED [DIRECTED_ROWS] = '{
        '{OP_QUERY, 32'd0, 32'd0, 1'b1, '{32'd0, ST_OK, POOL_SMALL, 1'b0}},
        '{OP_ALLOC, 32'd0, 32'd0, 1'b1, '{32'd0, ST_HEAP, POOL_NONE, 1'b0}},
        '{OP_ALLOC, 32'd1, 32'd0, 1'b1, '{32'd0, ST_OK, POOL_SMALL, 1'b0}},
        '{OP_ALLOC, 32'd16, 32'd0, 1'b1, '{32'd16, ST_OK, POOL_SMALL, 1'b0}},
        '{OP_ALLOC, 32'd17, 32'd0, 1'b1, '{32'd0, ST_OK, POOL_MID, 1'b0}},
        '{OP_ALLOC, 32'd32, 32'd0, 1'b1, '{32'd32, ST_OK, POOL_MID, 1'b0}},
        '{OP_ALLOC, 32'd33, 32'd0, 1'b1, '{32'd0, ST_OK, POOL_LARGE, 1'b0}},
        '{OP_ALLOC, 32'd96, 32'd0, 1'b1, '{32'd96, ST_OK, POOL_LARGE, 1'b0}},
        '{OP_ALLOC, 32'd97, 32'd0, 1'b1, '{32'd0, ST_HEAP, POOL_NONE, 1'b0}},
        '{OP_ALLOC, ALL_ONES, 32'd0, 1'b1, '{32'd0, ST_HEAP, POOL_NONE, 1'b0}},
        '{OP_QUERY, 32'd0, 32'd0, 1'b1, '{32'd0, ST_OK, POOL_SMALL, 1'b1}},
        '{OP_QUERY, 32'd0, 32'd8, 1'b1, '{32'd0, ST_HEAP, POOL_NONE, 1'b0}},
        '{OP_QUERY, 32'd0, 32'd16384, 1'b1, '{32'd0, ST_HEAP, POOL_NONE, 1'b0}},
        '{OP_QUERY, 32'd0, 32'd16416, 1'b1, '{32'd0, ST_OK, POOL_LARGE, 1'b0}},
        '{OP_QUERY, 32'd0, 32'd16368, 1'b1, '{32'd0, ST_OK, POOL_SMALL, 1'b0}},
        '{OP_FREE, 32'd0, 32'd16, 1'b1, '{32'd0, ST_OK, POOL_SMALL, 1'b0}},
        '{OP_FREE, 32'd0, 32'd16, 1'b1, '{32'd0, ST_DOUBLE, POOL_SMALL, 1'b0}},
        '{OP_FREE, 32'd0, 32'd16416, 1'b1, '{32'd0, ST_DOUBLE, POOL_LARGE, 1'b0}},
        '{OP_RESERVED, ALL_ONES, 32'd0, 1'b1, '{32'd0, ST_HEAP, POOL_NONE, 1'b0}},
        '{OP_FREE, 32'd0, ALL_ONES, 1'b1, '{32'd0, ST_HEAP, POOL_NONE, 1'b0}},
        '{OP_QUERY, 32'd0, 32'd49056, 1'b1, '{32'd0, ST_OK, POOL_LARGE, 1'b0}},
        '{OP_QUERY, 32'd0, 32'd49152, 1'b1, '{32'd0, ST_HEAP, POOL_NONE, 1'b0}},
        '{OP_FREE, 32'd0, 32'd0, 1'b1, '{32'd0, ST_OK, POOL_SMALL, 1'b0}},
        '{OP_ALLOC, 32'd5, 32'd0, 1'b0, '0},
        '{OP_ALLOC, 32'd64, 32'd0, 1'b0, '0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_operation;
    logic [31:0] i_request_size;
    logic [31:0] i_block_address;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_result_address;
    logic [1:0]  o_status;
    logic [1:0]  o_pool_hit;
    logic        o_is_allocated;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    logic [31:0] pool_base [3];
    bit          block_used [3][MAX_BLOCKS];
    int          used_count [3];
    t_result     awaited_results [$];
    int          failures;
    int          hold_asks;
    int          burst_left;

    size_class_bitmap_allocator_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_request_size   (i_request_size),
        .i_block_address  (i_block_address),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_address (o_result_address),
        .o_status         (o_status),
        .o_pool_hit       (o_pool_hit),
        .o_is_allocated   (o_is_allocated),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    function automatic logic [31:0] block_bytes(int p);
        case (p)
            0:       return SMALL_BYTES;
            1:       return MID_BYTES;
            default: return LARGE_BYTES;
        endcase
    endfunction

    function automatic logic [31:0] pool_blocks(int p);
        case (p)
            0:       return SMALL_BLOCKS;
            1:       return MID_BLOCKS;
            default: return LARGE_BLOCKS;
        endcase
    endfunction

    function automatic t_code size_class(logic [31:0] size);
        if (size >= 32'd1 && size <= 32'd16) return POOL_SMALL;
        if (size >= 32'd17 && size <= 32'd32) return POOL_MID;
        if (size >= 32'd33 && size <= 32'd96) return POOL_LARGE;
        return POOL_NONE;
    endfunction

    // Apply one request to the bitmap copy and return the word the block owes for it.
    function automatic t_result allocator_step(t_code op, logic [31:0] size,
                                               logic [31:0] addr);
        t_result     r;
        t_code       p;
        logic [31:0] d;
        logic        found;
        int          i;
        int          idx;
        r = '{32'd0, ST_HEAP, POOL_NONE, 1'b0};
        found = 1'b0;
        idx = 0;
        p = POOL_NONE;
        if (op == OP_ALLOC) begin
            p = size_class(size);
            if (p != POOL_NONE) begin
                r.pool = p;
                r.status = ST_FULL;
                i = 0;
                while (i < pool_blocks(p) && block_used[p][i]) i++;
                if (i < pool_blocks(p)) begin
                    block_used[p][i] = 1'b1;
                    used_count[p]++;
                    r.addr = pool_base[p] + i * block_bytes(p);
                    r.status = ST_OK;
                end
            end
        end else if (op == OP_FREE || op == OP_QUERY) begin
            // first pool in small, mid, large order that holds a block start here
            for (i = 0; i < 3 && !found; i++) begin
                d = addr - pool_base[i];
                if (d / block_bytes(i) < pool_blocks(i) && d % block_bytes(i) == 0) begin
                    found = 1'b1;
                    p = t_code'(i);
                    idx = d / block_bytes(i);
                end
            end
            if (found) begin
                r.pool = p;
                r.status = ST_OK;
                if (op == OP_FREE) begin
                    if (block_used[p][idx]) begin
                        block_used[p][idx] = 1'b0;
                        used_count[p]--;
                    end else begin
                        r.status = ST_DOUBLE;
                    end
                end else begin
                    r.used = block_used[p][idx];
                end
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] class_size(int c);
        logic [31:0] lo;
        logic [31:0] hi;
        case (c)
            0:       begin lo = 32'd1;  hi = 32'd16; end
            1:       begin lo = 32'd17; hi = 32'd32; end
            default: begin lo = 32'd33; hi = 32'd96; end
        endcase
        case ($urandom_range(0, 4))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // Allocation takes the lowest free block, so in-use blocks sit near the bottom.
    function automatic logic [31:0] pool_address(int p);
        int top;
        int idx;
        top = used_count[p] + 4;
        if (top > pool_blocks(p) - 1 || $urandom_range(0, 7) == 0) top = pool_blocks(p) - 1;
        idx = $urandom_range(0, top);
        return pool_base[p] + idx * block_bytes(p);
    endfunction

    function automatic void make_item(input bit filling, output t_code op,
                                      output logic [31:0] size, output logic [31:0] addr);
        int          r;
        int          p;
        logic [31:0] bytes;
        r = $urandom_range(0, 99);
        p = $urandom_range(0, 2);
        bytes = block_bytes(p);
        op = OP_QUERY;
        size = $urandom;
        addr = $urandom;
        if (filling) begin
            if (r < 92) begin
                op = OP_ALLOC;
                if (used_count[POOL_MID] < MID_BLOCKS && $urandom_range(0, 3) == 0) begin
                    size = class_size(POOL_MID);
                end else if (used_count[POOL_SMALL] < SMALL_BLOCKS) begin
                    size = class_size(POOL_SMALL);
                end else begin
                    size = class_size($urandom_range(1, 2));
                end
            end else begin
                addr = pool_address(p);
            end
        end else if (r < 40) begin
            op = OP_ALLOC;
            size = class_size(p);
        end else if (r < 75) begin
            op = (r < 58) ? OP_FREE : OP_QUERY;
            addr = pool_address(p);
        end else if (r < 83) begin
            op = ($urandom_range(0, 1) == 0) ? OP_FREE : OP_QUERY;
            case ($urandom_range(0, 2))
                0:       addr = pool_address(p) + $urandom_range(1, bytes - 1);
                1:       addr = pool_base[p] + (pool_blocks(p) + $urandom_range(0, 2)) * bytes;
                default: addr = pool_base[p] - bytes * $urandom_range(1, 2);
            endcase
        end else if (r < 93) begin
            op = t_code'($urandom_range(0, 3));
        end else begin
            op = OP_ALLOC;
            case ($urandom_range(0, 3))
                0:       size = 32'd0;
                1:       size = 32'd97;
                2:       size = ALL_ONES;
                default: size = 32'd1 << $urandom_range(7, 31);
            endcase
        end
    endfunction

    // Offer one word and hold it until taken, then pace the sender in bursts.
    task automatic send_word(t_code op, logic [31:0] size, logic [31:0] addr,
                             logic typed, t_result want);
        t_result model;
        int      gap;
        model = allocator_step(op, size, addr);
        awaited_results.push_back(typed ? want : model);
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_request_size <= size;
        i_block_address <= addr;
        do @(posedge i_clk); while (o_in_stall);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic write_reg(t_code index, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (index != CFG_UNUSED) pool_base[index] = value;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_traffic(int count);
        t_code       op;
        logic [31:0] size;
        logic [31:0] addr;
        repeat (count) begin
            make_item(1'b0, op, size, addr);
            send_word(op, size, addr, 1'b0, '0);
        end
    endtask

    task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
                $display("%0t: %s expected %h got %h", $time, label, want, got);
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("[size_class_bitmap_allocator_top] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("%0t: result word with none awaited, address %h",
                             $time, o_result_address);
                end
            end else begin
                want = awaited_results.pop_front();
                check_field("result_address", want.addr, o_result_address);
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("pool_hit", 32'(want.pool), 32'(o_pool_hit));
                check_field("is_allocated", 32'(want.used), 32'(o_is_allocated));
            end
        end
    end

    // Receiver: stall in spans of random style; honor a long hold when asked.
    initial begin : receiver
        int mode;
        int span;
        int seen;
        seen = 0;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_asks != seen) begin
                seen = hold_asks;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 80);
            repeat (span) begin
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= ~i_out_stall;
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        t_code       op;
        logic [31:0] size;
        logic [31:0] addr;
        logic [31:0] anchor;
        int          n;
        int          extra;
        failures = 0;
        hold_asks = 0;
        burst_left = 0;
        for (n = 0; n < 3; n++) begin
            pool_base[n] = 32'd0;
            used_count[n] = 0;
        end
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_operation <= OP_ALLOC;
        i_request_size <= 32'd0;
        i_block_address <= 32'd0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_SMALL_BASE;
        i_cfg_data <= 32'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < DIRECTED_ROWS; n++) begin
            send_word(DIRECTED[n].op, DIRECTED[n].size, DIRECTED[n].addr,
                      DIRECTED[n].typed, DIRECTED[n].want);
        end
        drain();

        // random bases; index past the list must be dropped
        write_reg(CFG_SMALL_BASE, $urandom);
        write_reg(CFG_MID_BASE, $urandom);
        write_reg(CFG_LARGE_BASE, $urandom);
        write_reg(CFG_UNUSED, $urandom);
        hold_asks++;
        run_traffic(120);
        drain();

        // small pool wraps past the top of the address space; fill small and mid
        write_reg(CFG_SMALL_BASE, ALL_ONES);
        write_reg(CFG_MID_BASE, 32'd0);
        write_reg(CFG_LARGE_BASE, 32'd0);
        n = 0;
        extra = 0;
        while (n < FILL_CAP && extra < 30) begin
            make_item(1'b1, op, size, addr);
            send_word(op, size, addr, 1'b0, '0);
            n++;
            if (used_count[POOL_SMALL] == SMALL_BLOCKS && used_count[POOL_MID] == MID_BLOCKS)
                extra++;
        end
        drain();

        // partly overlapping pools from one anchor
        anchor = $urandom;
        write_reg(CFG_SMALL_BASE, anchor);
        write_reg(CFG_MID_BASE, anchor + SMALL_BYTES * $urandom_range(0, 1100));
        write_reg(CFG_LARGE_BASE, anchor + MID_BYTES * $urandom_range(0, 600));
        hold_asks++;
        run_traffic(100);
        drain();

        write_reg(CFG_SMALL_BASE, 32'd0);
        write_reg(CFG_MID_BASE, ALL_ONES);
        write_reg(CFG_LARGE_BASE, ALL_ONES);
        write_reg(CFG_UNUSED, ALL_ONES);
        run_traffic(60);
        drain();

        if (failures == 0 && awaited_results.size() == 0) begin
            $display("[size_class_bitmap_allocator_top] OK");
        end else begin
            $display("[size_class_bitmap_allocator_top] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/scab_pkg.sv
sv/scab_bitmap_ram.sv
sv/scab_addr_unit.sv
sv/size_class_bitmap_allocator_top.sv
tb/sv/testbench.sv
